FILE: rtl/qau_pkg.sv
`default_nettype none

package qau_pkg;

  typedef enum logic [1:0] {
    MODE_PROD = 2'd0,
    MODE_CONJ = 2'd1,
    MODE_ROT  = 2'd2
  } mode_t;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] sum_t;

  typedef comp_t quat_t [4];
  typedef prod_t prod_arr_t [4][4];
  typedef sum_t sum_arr_t [4];

  typedef struct packed {
    logic         sat;
    logic signed [15:0] v;
  } rs_t;

  // signed product sums; pc conjugates the left operand, qc the right one
  function automatic sum_arr_t qsum(prod_arr_t m, logic pc, logic qc);
    prod_arr_t n;
    sum_arr_t  r;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        n[i][j] = ((pc && (i != 0)) ^ (qc && (j != 0))) ? -m[i][j] : m[i][j];
      end
    end
    r[0] = 34'(n[0][0]) - 34'(n[1][1]) - 34'(n[2][2]) - 34'(n[3][3]);
    r[1] = 34'(n[0][1]) + 34'(n[1][0]) + 34'(n[2][3]) - 34'(n[3][2]);
    r[2] = 34'(n[0][2]) - 34'(n[1][3]) + 34'(n[2][0]) + 34'(n[3][1]);
    r[3] = 34'(n[0][3]) + 34'(n[1][2]) - 34'(n[2][1]) + 34'(n[3][0]);
    return r;
  endfunction

  // Q2.28 to Q1.14, nearest with ties up, then clip to 16 bits
  function automatic rs_t round_sat(sum_t s);
    logic signed [34:0] b;
    logic signed [20:0] q;
    rs_t                r;
    b = 35'(s) + 35'sd8192;
    q = b[34:14];
    priority if (q > 21'sd32767) begin
      r.sat = 1'b1;
      r.v   = 16'sh7fff;
    end else if (q < -21'sd32768) begin
      r.sat = 1'b1;
      r.v   = 16'sh8000;
    end else begin
      r.sat = 1'b0;
      r.v   = q[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_arith_unit.sv
`default_nettype none
// throughput: one word per cycle, stalls pass back stage by stage through the valid chain
// pipeline: products, sums, round/clip, second products, sums, round/clip into output register
// reset: synchronous, clears all stage valid bits; data registers are not reset

module quaternion_arith_unit
  import qau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  wire logic [1:0]   s_tuser,  // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [63:0]       m_tdata,  // r_w, r_x, r_y, r_z
  output logic [0:0]        m_tuser   // saturated
);

  logic [6:1] v;
  logic [6:1] adv;

  quat_t     a_in, b_in;
  logic      rot_in, conj_in;

  prod_arr_t pr1;
  quat_t     a1;
  logic      conj1, rot1;

  sum_arr_t  s1;
  quat_t     a2;
  logic      rot2;

  quat_t     t3, a3;
  logic      sat3, rot3;

  prod_arr_t pr2;
  quat_t     t4;
  logic      sat4, rot4;

  sum_arr_t  s2;
  quat_t     t5;
  logic      sat5, rot5;

  logic [63:0] out_data;
  logic        out_sat;

  rs_t       rs1 [4];
  rs_t       rs2 [4];
  sum_arr_t  s1_next, s2_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_in[k] = s_tdata[16*k +: 16];
      b_in[k] = s_tdata[64+16*k +: 16];
    end
    rot_in  = (s_tuser == MODE_ROT);
    conj_in = (s_tuser == MODE_CONJ);
    if (rot_in) begin
      b_in[0] = '0;
    end
  end

  always_comb begin
    adv[6] = !v[6] || m_tready;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign s_tready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_comb begin
    s1_next = qsum(pr1, conj1, 1'b0);
    s2_next = qsum(pr2, 1'b0, 1'b1);
    for (int k = 0; k < 4; k++) begin
      rs1[k] = round_sat(s1[k]);
      rs2[k] = round_sat(s2[k]);
    end
  end

  // first pass products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr1[i][j] <= a_in[i] * b_in[j];
        end
      end
      a1    <= a_in;
      conj1 <= conj_in;
      rot1  <= rot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s1   <= s1_next;
      a2   <= a1;
      rot2 <= rot1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 4; k++) begin
        t3[k] <= rs1[k].v;
      end
      sat3 <= rs1[0].sat | rs1[1].sat | rs1[2].sat | rs1[3].sat;
      a3   <= a2;
      rot3 <= rot2;
    end
  end

  // second pass products, t times conj(a)
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr2[i][j] <= t3[i] * a3[j];
        end
      end
      t4   <= t3;
      sat4 <= sat3;
      rot4 <= rot3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s2   <= s2_next;
      t5   <= t4;
      sat5 <= sat4;
      rot5 <= rot4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      if (rot5) begin
        out_data <= {rs2[3].v, rs2[2].v, rs2[1].v, 16'h0000};
        out_sat  <= sat5 | rs2[0].sat | rs2[1].sat | rs2[2].sat | rs2[3].sat;
      end else begin
        out_data <= {t5[3], t5[2], t5[1], t5[0]};
        out_sat  <= sat5;
      end
    end
  end

  assign m_tvalid = v[6];
  assign m_tdata  = out_data;
  assign m_tuser  = out_sat;

`ifndef SYNTHESIS
  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (&v) && !m_tready |-> !s_tready)
    else $error("input taken while every stage is full and stalled");

  a_sat_clip : assert property (@(posedge clk) disable iff (rst)
    v[3] && sat3 |-> (t3[0] == 16'sh7fff) || (t3[0] == 16'sh8000) ||
                     (t3[1] == 16'sh7fff) || (t3[1] == 16'sh8000) ||
                     (t3[2] == 16'sh7fff) || (t3[2] == 16'sh8000) ||
                     (t3[3] == 16'sh7fff) || (t3[3] == 16'sh8000))
    else $error("clip flag set with no clipped component");

  a_reset_empty : assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output word valid right after reset");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_quaternion_arith_unit.sv
`default_nettype none

module tb_quaternion_arith_unit;
  import qau_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
  } quat_word_t;

  typedef struct packed {
    logic             sat;
    logic [3:0][15:0] r;
  } quat_res_t;

  typedef longint qvec_t [4];

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  logic [1:0]   s_tuser = '0;  // mode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;       // r_w, r_x, r_y, r_z
  logic [0:0]   m_tuser;       // saturated

  quat_word_t pending_words[$];
  quat_res_t  expected_results[$];
  quat_word_t offered;
  bit         calm = 1'b0;
  int         hold_tag = 0;
  int         hold_seen = 0;
  int         hold_cnt = 0;
  int         mismatch_count = 0;
  int         cycles = 0;
  string      comp_name [4] = '{"r_w", "r_x", "r_y", "r_z"};

  quaternion_arith_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round half up from Q2.28 to Q1.14, then clip to 16 bits
  function automatic longint round_clip(longint s, inout bit sat);
    longint q;
    q = (s + 64'sd8192) >>> 14;
    if (q > 32767) begin
      sat = 1'b1;
      q = 32767;
    end else if (q < -32768) begin
      sat = 1'b1;
      q = -32768;
    end
    return q;
  endfunction

  // r = p' * q', where a set flag negates the vector part of that operand
  function automatic void hamilton(input qvec_t p, input bit pc, input qvec_t q, input bit qc,
                                   output qvec_t r, inout bit sat);
    longint w1, x1, y1, z1, w2, x2, y2, z2;
    w1 = p[0]; x1 = pc ? -p[1] : p[1]; y1 = pc ? -p[2] : p[2]; z1 = pc ? -p[3] : p[3];
    w2 = q[0]; x2 = qc ? -q[1] : q[1]; y2 = qc ? -q[2] : q[2]; z2 = qc ? -q[3] : q[3];
    r[0] = round_clip(w1 * w2 - x1 * x2 - y1 * y2 - z1 * z2, sat);
    r[1] = round_clip(w1 * x2 + x1 * w2 + y1 * z2 - z1 * y2, sat);
    r[2] = round_clip(w1 * y2 - x1 * z2 + y1 * w2 + z1 * x2, sat);
    r[3] = round_clip(w1 * z2 + x1 * y2 - y1 * x2 + z1 * w2, sat);
  endfunction

  function automatic quat_res_t quat_unit_result(quat_word_t w);
    qvec_t     a, b, t, r;
    bit        sat;
    quat_res_t res;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(w.a[i]));
      b[i] = longint'($signed(w.b[i]));
    end
    case (w.mode)
      MODE_CONJ: begin
        hamilton(a, 1'b1, b, 1'b0, r, sat);
      end
      MODE_ROT: begin
        b[0] = 0;
        hamilton(a, 1'b0, b, 1'b0, t, sat);
        hamilton(t, 1'b0, a, 1'b1, r, sat);
        r[0] = 0;
      end
      default: begin
        hamilton(a, 1'b0, b, 1'b0, r, sat);
      end
    endcase
    res.sat = sat;
    for (int i = 0; i < 4; i++) res.r[i] = 16'(r[i]);
    return res;
  endfunction

  function automatic quat_word_t mk(logic [1:0] mode, int aw, int ax, int ay, int az,
                                    int bw, int bx, int by, int bz);
    quat_word_t w;
    w.mode = mode;
    w.a = {16'(az), 16'(ay), 16'(ax), 16'(aw)};
    w.b = {16'(bz), 16'(by), 16'(bx), 16'(bw)};
    return w;
  endfunction

  function automatic logic [15:0] rand_comp(int style);
    logic [15:0] v;
    case (style)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 32768) - 16384);
      2: v = 16'($urandom_range(0, 128) - 64);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h4000;
          3: v = 16'hc000;
          default: v = 16'h0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic quat_word_t rand_word();
    quat_word_t w;
    int         style, m;
    style = $urandom_range(0, 3);
    m = $urandom_range(0, 15);
    if (m < 5) w.mode = MODE_PROD;
    else if (m < 10) w.mode = MODE_CONJ;
    else if (m < 15) w.mode = MODE_ROT;
    else w.mode = MODE_SPARE;
    for (int i = 0; i < 4; i++) begin
      w.a[i] = rand_comp(style);
      w.b[i] = rand_comp(style);
    end
    return w;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(quat_unit_result(offered));
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
          offered = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered.b, offered.a};
          s_tuser <= offered.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_res_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: tdata %h tuser %b", m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          exp_res = expected_results.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_tdata[16*i +: 16] !== exp_res.r[i]) begin
              $error("%s: expected %0d, got %0d", comp_name[i], $signed(exp_res.r[i]),
                     $signed(m_tdata[16*i +: 16]));
              mismatch_count++;
            end
          end
          if (m_tuser[0] !== exp_res.sat) begin
            $error("saturated: expected %0d, got %0d", exp_res.sat, m_tuser[0]);
            mismatch_count++;
          end
        end
      end
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, zero and extreme operands
    pending_words.push_back(mk(MODE_PROD, 16384, 0, 0, 0, 1000, -2000, 3000, -4000));
    pending_words.push_back(mk(MODE_PROD, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(MODE_PROD, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767));
    pending_words.push_back(mk(MODE_PROD, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768));
    pending_words.push_back(mk(MODE_PROD, -32768, -32768, -32768, -32768,
                               32767, 32767, 32767, 32767));
    // conjugate of -2 is exact
    pending_words.push_back(mk(MODE_CONJ, 0, -32768, -32768, -32768, 0, 32767, 32767, 32767));
    pending_words.push_back(mk(MODE_CONJ, 16384, 16384, 0, 0, 0, 0, 16384, 0));
    pending_words.push_back(mk(MODE_CONJ, -32768, 32767, -32768, 32767,
                               32767, -32768, 32767, -32768));
    // rotations, clipping in the intermediate
    pending_words.push_back(mk(MODE_ROT, 11585, 11585, 0, 0, 0, 0, 16384, 0));
    pending_words.push_back(mk(MODE_ROT, -32768, -32768, -32768, -32768,
                               123, 32767, 32767, 32767));
    pending_words.push_back(mk(MODE_ROT, 16384, 0, 0, 0, -5, 32767, -32768, 1));
    pending_words.push_back(mk(MODE_ROT, 3, -1, 1, 2, 32767, 8192, -8192, 8191));
    pending_words.push_back(mk(MODE_ROT, 20000, -20000, 20000, -20000,
                               -32768, -32768, -32768, -32768));
    pending_words.push_back(mk(MODE_SPARE, 100, 200, -300, 400, -500, 600, 700, -800));
    pending_words.push_back(mk(MODE_SPARE, 32767, -32768, 32767, -32768,
                               32767, 32767, -32768, -32768));
    // ties round up
    pending_words.push_back(mk(MODE_PROD, 1, 0, 0, 0, 8192, 0, 0, 0));
    pending_words.push_back(mk(MODE_PROD, -1, 0, 0, 0, 8192, 0, 0, 0));
    pending_words.push_back(mk(MODE_PROD, 3, 0, 0, 0, -8192, 0, 0, 0));
    pending_words.push_back(mk(MODE_CONJ, 0, 1, 0, 0, 0, 8192, 0, 0));
    // right at the clip limits
    pending_words.push_back(mk(MODE_PROD, 32767, 0, 0, 0, 16384, 0, 0, 0));
    pending_words.push_back(mk(MODE_PROD, -32768, 0, 0, 0, 16384, 0, 0, 0));
    pending_words.push_back(mk(MODE_PROD, -32768, 0, 0, 0, -16384, 0, 0, 0));

    repeat (210) pending_words.push_back(rand_word());
    // sender pauses until everything is back
    wait_drained();

    calm = 1'b1;
    repeat (150) pending_words.push_back(rand_word());
    do @(negedge clk);
    while (pending_words.size() != 0);
    calm = 1'b0;

    // long receiver hold while words keep coming
    repeat (120) pending_words.push_back(rand_word());
    hold_tag++;
    repeat (250) pending_words.push_back(rand_word());
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
